FILE: rtl/assert_macros.svh
// Assertion helper macros shared by the mapper RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BPAM_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
`define BPAM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BPAM_ASSERT(lbl, clk, rstn, prop)
`define BPAM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/bpam_pkg.sv
// Shared types and constants of the bitmap page address mapper.
// Depends on nothing; used by bpam_cfg, bpam_back and the top level.
package bpam_pkg;
	localparam int STRIDE_W    = 24;
	localparam int PAGE_W      = 21;
	localparam int SEQ_W       = 6;
	localparam int HDR_W       = 7;
	localparam int DIV_STEPS   = 4;
	localparam int BASE_HEADER = 4;
	localparam int HEADER_MAX  = 127;
	localparam int PAGE_RESET  = 4096;
	localparam int SEQ_RESET   = 16;

	typedef enum logic {
		REG_PAGE_BYTES = 1'b0,
		REG_SEQ_BYTES  = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} back_state_t;

	typedef struct packed {
		logic [STRIDE_W-1:0] stride;
		logic [PAGE_W-1:0]   page_bytes;
		logic [SEQ_W-1:0]    seq_bytes;
		logic                bad;
	} cfg_t;
endpackage

FILE: rtl/bpam_cfg.sv
// Configuration registers and derived extent stride.
// Depends on bpam_pkg.
module bpam_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output bpam_pkg::cfg_t      cfg
);
	logic [bpam_pkg::PAGE_W-1:0] page_q;
	logic [bpam_pkg::SEQ_W-1:0]  seq_q;
	bpam_pkg::reg_idx_t          idx;
	logic [bpam_pkg::PAGE_W-1:0] used;
	logic [bpam_pkg::PAGE_W-1:0] diff;
	logic [7:0]                  full_hdr;
	logic                        wr;

	assign pready = 1'b1;
	assign idx    = bpam_pkg::reg_idx_t'(paddr[2]);
	assign wr     = psel & penable & pwrite;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q <= bpam_pkg::PAGE_W'(bpam_pkg::PAGE_RESET);
			seq_q  <= bpam_pkg::SEQ_W'(bpam_pkg::SEQ_RESET);
		end else if (wr) begin
			case (idx)
				bpam_pkg::REG_PAGE_BYTES: page_q <= pwdata[bpam_pkg::PAGE_W-1:0];
				bpam_pkg::REG_SEQ_BYTES:  seq_q  <= pwdata[bpam_pkg::SEQ_W-1:0];
				default: ;
			endcase
		end
	end

	// Register reads.
	always_comb begin
		case (idx)
			bpam_pkg::REG_PAGE_BYTES: prdata = 32'(page_q);
			bpam_pkg::REG_SEQ_BYTES:  prdata = 32'(seq_q);
			default:                  prdata = '0;
		endcase
	end

	// Stride is the bitmap bit count plus one; the bit count saturates at zero.
	assign used     = bpam_pkg::PAGE_W'(bpam_pkg::BASE_HEADER) + bpam_pkg::PAGE_W'(seq_q);
	assign diff     = (page_q > used) ? (page_q - used) : '0;
	assign full_hdr = 8'(bpam_pkg::BASE_HEADER) + {1'b0, seq_q, 1'b0};

	always_comb begin
		cfg.stride     = {diff, 3'b000} + bpam_pkg::STRIDE_W'(1);
		cfg.page_bytes = page_q;
		cfg.seq_bytes  = seq_q;
		cfg.bad        = (page_q <= bpam_pkg::PAGE_W'(full_hdr));
	end
endmodule

FILE: rtl/bpam_queue.sv
// Two-entry queue between the accepting front and the divider back end.
// Depends on the assertion macros.
`include "assert_macros.svh"
module bpam_queue #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_pop,
	output logic [W-1:0] out_data
);
	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         push;
	logic         pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid & in_ready;
	assign pop       = out_pop & out_valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	`BPAM_ASSERT(a_count_max, clk, arst_n, count_q != 2'd3)
	`BPAM_ASSERT_NEXT(a_count_up, clk, arst_n, push && !pop, count_q == $past(count_q) + 2'd1)
endmodule

FILE: rtl/bpam_back.sv
// Back end: iterative divider by the stride and the result register.
// Depends on bpam_pkg and the assertion macros.
`include "assert_macros.svh"
module bpam_back #(
	parameter int W = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  bpam_pkg::cfg_t cfg,
	input  logic           q_valid,
	input  logic [W-1:0]   q_data,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           bitmap,
	output logic [W-1:0]   extent,
	output logic [W-1:0]   owning,
	output logic [W-1:0]   bitpos,
	output logic [W-1:0]   next_page,
	output logic           next_ok
);
	localparam int CYC   = (W + bpam_pkg::DIV_STEPS - 1) / bpam_pkg::DIV_STEPS;
	localparam int DW    = CYC * bpam_pkg::DIV_STEPS;
	localparam int CNT_W = $clog2(CYC + 1);
	localparam int XW    = ((W > bpam_pkg::STRIDE_W) ? W : bpam_pkg::STRIDE_W) + 1;

	bpam_pkg::back_state_t         state_q;
	bpam_pkg::back_state_t         state_n;
	logic [CNT_W-1:0]              cnt_q;
	logic [bpam_pkg::STRIDE_W-1:0] rem_q;
	logic [DW-1:0]                 quo_q;
	logic [W-1:0]                  page_q;
	logic [bpam_pkg::STRIDE_W-1:0] r_c;
	logic [DW-1:0]                 q_c;
	logic [bpam_pkg::STRIDE_W:0]   t_c;
	logic                          load;
	logic                          last;
	logic                          out_valid_q;
	logic                          bitmap_q;
	logic                          ok_q;
	logic [W-1:0]                  extent_q;
	logic [W-1:0]                  owning_q;
	logic [W-1:0]                  bitpos_q;
	logic [W-1:0]                  next_q;
	logic [XW-1:0]                 rem_x;
	logic [XW-1:0]                 page_x;
	logic [XW-1:0]                 sum_x;
	logic                          fits;

	// DIV_STEPS restoring division steps per cycle.
	always_comb begin
		r_c = rem_q;
		q_c = quo_q;
		t_c = '0;
		for (int i = 0; i < bpam_pkg::DIV_STEPS; i++) begin
			t_c = {r_c, q_c[DW-1]};
			q_c = {q_c[DW-2:0], 1'b0};
			if (t_c >= {1'b0, cfg.stride}) begin
				t_c    = t_c - {1'b0, cfg.stride};
				q_c[0] = 1'b1;
			end
			r_c = t_c[bpam_pkg::STRIDE_W-1:0];
		end
	end

	assign last = (cnt_q == CNT_W'(CYC - 1));
	assign load = (state_q == bpam_pkg::ST_DONE) && (!out_valid_q || out_ready);

	// Next state.
	always_comb begin
		state_n = state_q;
		case (state_q)
			bpam_pkg::ST_IDLE: if (q_valid) state_n = bpam_pkg::ST_DIV;
			bpam_pkg::ST_DIV:  if (last) state_n = bpam_pkg::ST_DONE;
			bpam_pkg::ST_DONE: begin
				if (load) state_n = q_valid ? bpam_pkg::ST_DIV : bpam_pkg::ST_IDLE;
			end
			default:           state_n = bpam_pkg::ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		case (state_q)
			bpam_pkg::ST_IDLE: q_pop = q_valid;
			bpam_pkg::ST_DONE: q_pop = load & q_valid;
			default:           q_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpam_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			if (q_pop) begin
				cnt_q <= '0;
			end else if (state_q == bpam_pkg::ST_DIV) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Divider datapath.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			page_q <= q_data;
			quo_q  <= DW'(q_data);
			rem_q  <= '0;
		end else if (state_q == bpam_pkg::ST_DIV) begin
			rem_q <= r_c;
			quo_q <= q_c;
		end
	end

	// Result arithmetic from quotient and remainder.
	assign rem_x  = XW'(rem_q);
	assign page_x = XW'(page_q);
	assign sum_x  = page_x + XW'(cfg.stride);
	assign fits   = ((sum_x >> W) == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bitmap_q <= (rem_q == '0);
			ok_q     <= (rem_q == '0) && fits;
			extent_q <= quo_q[W-1:0];
			owning_q <= W'(page_x - rem_x);
			bitpos_q <= W'(rem_x - XW'(1));
			next_q   <= ((rem_q == '0) && fits) ? W'(sum_x) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign bitmap    = bitmap_q;
	assign next_ok   = ok_q;
	assign extent    = extent_q;
	assign owning    = owning_q;
	assign bitpos    = bitpos_q;
	assign next_page = next_q;

	`BPAM_ASSERT(a_rem_below_stride, clk, arst_n, (state_q == bpam_pkg::ST_DIV) |-> (rem_q < cfg.stride))
	`BPAM_ASSERT(a_ok_needs_bitmap, clk, arst_n, (out_valid_q && ok_q) |-> bitmap_q)
	`BPAM_ASSERT(a_bitmap_pos_ones, clk, arst_n, (out_valid_q && bitmap_q) |-> (&bitpos_q))
endmodule

FILE: rtl/bitmap_page_address_mapper.sv
// The divider retires four quotient bits per cycle and works on one page id at a time;
// a two-entry queue absorbs bursts, and a finished result waits until out_ready frees
// the output register.
// Reset: arst_n clears all control; registers return to 4096-byte pages and
// 16-byte sequence numbers.
// Top level; depends on bpam_pkg, bpam_cfg, bpam_queue and bpam_back.
module bitmap_page_address_mapper #(
	parameter int PAGE_ID_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] page_number,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_bitmap_page,
	output logic        has_writer_sequence,
	output logic [63:0] extent_index,
	output logic [63:0] owning_bitmap_page,
	output logic [63:0] bit_position,
	output logic [63:0] next_bitmap_page,
	output logic        next_ok,
	output logic [6:0]  header_bytes,
	output logic [20:0] content_bytes,
	output logic        config_bad
);
	bpam_pkg::cfg_t          cfg;
	logic                    q_valid;
	logic                    q_pop;
	logic [PAGE_ID_BITS-1:0] q_data;
	logic [PAGE_ID_BITS-1:0] extent;
	logic [PAGE_ID_BITS-1:0] owning;
	logic [PAGE_ID_BITS-1:0] bitpos;
	logic [PAGE_ID_BITS-1:0] next_page;
	logic                    bitmap;
	logic [7:0]              hdr_raw;
	logic [bpam_pkg::HDR_W-1:0] hdr;

	bpam_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	// Front: accept beats, keep only the page id bits.
	bpam_queue #(.W(PAGE_ID_BITS)) u_queue (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(page_number[PAGE_ID_BITS-1:0]), .out_valid(q_valid),
		.out_pop(q_pop), .out_data(q_data)
	);

	bpam_back #(.W(PAGE_ID_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .q_valid(q_valid), .q_data(q_data),
		.q_pop(q_pop), .out_valid(out_valid), .out_ready(out_ready), .bitmap(bitmap),
		.extent(extent), .owning(owning), .bitpos(bitpos), .next_page(next_page),
		.next_ok(next_ok)
	);

	// Header holds one sequence number on bitmap pages and two on data pages.
	assign hdr_raw = 8'(bpam_pkg::BASE_HEADER)
		+ (bitmap ? {2'b00, cfg.seq_bytes} : {1'b0, cfg.seq_bytes, 1'b0});
	assign hdr = (hdr_raw > 8'(bpam_pkg::HEADER_MAX)) ?
		bpam_pkg::HDR_W'(bpam_pkg::HEADER_MAX) : hdr_raw[bpam_pkg::HDR_W-1:0];

	assign is_bitmap_page      = bitmap;
	assign has_writer_sequence = ~bitmap;
	assign extent_index        = 64'(extent);
	assign owning_bitmap_page  = 64'(owning);
	assign bit_position        = 64'(bitpos);
	assign next_bitmap_page    = 64'(next_page);
	assign header_bytes        = hdr;
	assign content_bytes       = cfg.bad ? '0 : (cfg.page_bytes - bpam_pkg::PAGE_W'(hdr));
	assign config_bad          = cfg.bad;
endmodule
